FILE: design/asap_pkg.sv
// asap_pkg: shared types, character codes and the colour table of the ANSI SGR
// attribute parser. Depends on nothing; used by ansi_sgr_attribute_parser.
package asap_pkg;

	// Character codes
	localparam logic [7:0] CH_ESC      = 8'd27;
	localparam logic [7:0] CH_LBRACKET = 8'd91;
	localparam logic [7:0] CH_SEMI     = 8'd59;
	localparam logic [7:0] CH_M        = 8'd109;
	localparam logic [7:0] CH_ZERO     = 8'd48;
	localparam logic [7:0] CH_NINE     = 8'd57;
	localparam logic [7:0] CH_THREE    = 8'd51;
	localparam logic [7:0] CH_FOUR     = 8'd52;
	localparam logic [7:0] CH_FIVE     = 8'd53;
	localparam logic [7:0] CH_SEVEN    = 8'd55;
	localparam logic [7:0] PRINT_LOW   = 8'd32;
	localparam logic [7:0] PRINT_END   = 8'd127;

	// Colour indices
	localparam logic [2:0] COLOR_WHITE = 3'd5;
	localparam logic [2:0] COLOR_GREY  = 3'd6;
	localparam logic [2:0] COLOR_CYAN  = 3'd7;

	// Underline styles
	localparam logic [1:0] UL_CYAN = 2'd0;
	localparam logic [1:0] UL_GREY = 2'd1;

	// Register indexes
	typedef enum logic {
		REG_DEFAULT_COLOR   = 1'b0,
		REG_UNDERLINE_STYLE = 1'b1
	} reg_idx_t;

	// SGR 30..37 to block colour index
	function automatic logic [2:0] fg_colour_lut(input logic [2:0] code);
		logic [2:0] res;
		unique case (code)
			3'd0: res = 3'd6;
			3'd1: res = 3'd1;
			3'd2: res = 3'd2;
			3'd3: res = 3'd0;
			3'd4: res = 3'd3;
			3'd5: res = 3'd4;
			3'd6: res = 3'd7;
			3'd7: res = 3'd5;
			default: res = 3'd5;
		endcase
		return res;
	endfunction

	// Result item fields
	typedef struct packed {
		logic [2:0] underline_color;
		logic       underline_on;
		logic       blink_on;
		logic [2:0] color_index;
		logic [6:0] glyph_index;
	} glyph_t;

endpackage

FILE: design/ansi_sgr_attribute_parser.sv
// ansi_sgr_attribute_parser: byte-stream SGR escape parser giving glyph items
// with colour, blink and underline attributes. Depends on asap_pkg.
//
// Channel  | Dir | Signals                          | Item
// s        | in  | s_tvalid s_tready s_tdata s_tuser | text byte, string start flag
// m        | out | m_tvalid m_tready m_tdata          | glyph with attributes
// apb      | in  | psel penable pwrite paddr pwdata   | default_color, underline_style
//
// One byte is accepted per cycle unless m stalls. A byte is held in the input
// register, decoded against the parser state, and its glyph (if any) is then
// registered in the output register, which drives m_tvalid.
// Parser state and attributes update when the byte leaves the input register.
// A stall on m holds the byte in the input register; a new byte is still taken
// as long as the output register is free or being emptied.
// arst_n clears parser state, attributes, valid flags, config regs at once.
module ansi_sgr_attribute_parser (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tuser,   // [0] string_start
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [6:0] glyph_index, [9:7] color_index,
	                               // [10] blink_on, [11] underline_on,
	                               // [14:12] underline_color, [15] zero
	// Configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_ESC  = 2'd1,
		PH_SEQ  = 2'd2
	} phase_t;

	// Configuration registers
	logic [2:0] default_color_q;
	logic [1:0] underline_style_q;

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// Parser state
	phase_t     phase_q;
	logic       blink_q, ul_q;
	logic [2:0] color_q;
	logic       pblink_q, pul_q, pcv_q;
	logic [2:0] pcolor_q;
	logic [1:0] dcount_q;
	logic [7:0] d1_q, d2_q;

	// Output register
	logic             out_valid_q;
	asap_pkg::glyph_t out_q;

	logic advance;
	logic cfg_wr;

	// Next state
	phase_t     phase_n;
	logic       blink_n, ul_n;
	logic [2:0] color_n;
	logic       pblink_n, pul_n, pcv_n;
	logic [2:0] pcolor_n;
	logic [1:0] dcount_n;
	logic [7:0] d1_n, d2_n;
	logic       emit;
	asap_pkg::glyph_t glyph;

	// Judged code
	logic       j_pblink, j_pul, j_pcv;
	logic [2:0] j_pcolor;

	// Effective state after string start
	phase_t     ph_e;
	logic       blink_e, ul_e;
	logic [2:0] color_e;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	always_comb begin
		unique case (asap_pkg::reg_idx_t'(paddr[2]))
			asap_pkg::REG_DEFAULT_COLOR:   prdata = {29'd0, default_color_q};
			asap_pkg::REG_UNDERLINE_STYLE: prdata = {30'd0, underline_style_q};
			default:                       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q   <= asap_pkg::COLOR_WHITE;
			underline_style_q <= 2'd0;
		end else if (cfg_wr) begin
			unique case (asap_pkg::reg_idx_t'(paddr[2]))
				asap_pkg::REG_DEFAULT_COLOR:   default_color_q   <= pwdata[2:0];
				asap_pkg::REG_UNDERLINE_STYLE: underline_style_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	// Judge the code gathered so far, as at ';' or 'm'
	always_comb begin
		j_pblink = pblink_q;
		j_pul    = pul_q;
		j_pcv    = pcv_q;
		j_pcolor = pcolor_q;
		if (dcount_q == 2'd1) begin
			if (d1_q == asap_pkg::CH_ZERO) begin
				j_pblink = 1'b0;
				j_pul    = 1'b0;
				j_pcolor = default_color_q;
				j_pcv    = 1'b1;
			end else if (d1_q == asap_pkg::CH_FOUR) begin
				j_pul = 1'b1;
			end else if (d1_q == asap_pkg::CH_FIVE) begin
				j_pblink = 1'b1;
			end
		end else if (dcount_q == 2'd2 && d1_q == asap_pkg::CH_THREE &&
		             d2_q >= asap_pkg::CH_ZERO && d2_q <= asap_pkg::CH_SEVEN) begin
			j_pcolor = asap_pkg::fg_colour_lut(d2_q[2:0]);
			j_pcv    = 1'b1;
		end
	end

	always_comb begin
		ph_e    = start_s1 ? PH_IDLE : phase_q;
		blink_e = start_s1 ? 1'b0 : blink_q;
		ul_e    = start_s1 ? 1'b0 : ul_q;
		color_e = start_s1 ? asap_pkg::COLOR_WHITE : color_q;

		phase_n  = ph_e;
		blink_n  = blink_e;
		ul_n     = ul_e;
		color_n  = color_e;
		pblink_n = pblink_q;
		pul_n    = pul_q;
		pcv_n    = pcv_q;
		pcolor_n = pcolor_q;
		dcount_n = dcount_q;
		d1_n     = d1_q;
		d2_n     = d2_q;
		emit     = 1'b0;

		glyph.glyph_index = 7'(byte_s1 - asap_pkg::PRINT_LOW);
		glyph.color_index = color_e;
		glyph.blink_on    = blink_e;
		glyph.underline_on = ul_e;
		if (!ul_e)
			glyph.underline_color = 3'd0;
		else if (underline_style_q == asap_pkg::UL_CYAN)
			glyph.underline_color = asap_pkg::COLOR_CYAN;
		else if (underline_style_q == asap_pkg::UL_GREY)
			glyph.underline_color = asap_pkg::COLOR_GREY;
		else
			glyph.underline_color = color_e;

		unique case (ph_e)
			PH_ESC: begin
				if (byte_s1 == asap_pkg::CH_LBRACKET) begin
					// Sequence opens: pending starts from current attributes
					phase_n  = PH_SEQ;
					pblink_n = blink_e;
					pul_n    = ul_e;
					pcv_n    = 1'b0;
					pcolor_n = 3'd0;
					dcount_n = 2'd0;
					d1_n     = 8'd0;
					d2_n     = 8'd0;
				end else begin
					phase_n = PH_IDLE;
				end
			end
			PH_SEQ: begin
				if (byte_s1 >= asap_pkg::CH_ZERO && byte_s1 <= asap_pkg::CH_NINE) begin
					if (dcount_q == 2'd0)
						d1_n = byte_s1;
					else if (dcount_q == 2'd1)
						d2_n = byte_s1;
					if (dcount_q != 2'd3)
						dcount_n = dcount_q + 2'd1;
				end else if (byte_s1 == asap_pkg::CH_SEMI ||
				             byte_s1 == asap_pkg::CH_M) begin
					pblink_n = j_pblink;
					pul_n    = j_pul;
					pcv_n    = j_pcv;
					pcolor_n = j_pcolor;
					dcount_n = 2'd0;
					d1_n     = 8'd0;
					d2_n     = 8'd0;
					if (byte_s1 == asap_pkg::CH_M) begin
						blink_n = j_pblink;
						ul_n    = j_pul;
						if (j_pcv)
							color_n = j_pcolor;
						phase_n = PH_IDLE;
					end
				end else begin
					// Abandoned sequence, byte swallowed
					dcount_n = 2'd0;
					d1_n     = 8'd0;
					d2_n     = 8'd0;
					phase_n  = PH_IDLE;
				end
			end
			default: begin
				if (byte_s1 == asap_pkg::CH_ESC)
					phase_n = PH_ESC;
				else if (byte_s1 >= asap_pkg::PRINT_LOW && byte_s1 < asap_pkg::PRINT_END)
					emit = 1'b1;
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			blink_q  <= 1'b0;
			ul_q     <= 1'b0;
			color_q  <= asap_pkg::COLOR_WHITE;
			pblink_q <= 1'b0;
			pul_q    <= 1'b0;
			pcv_q    <= 1'b0;
			pcolor_q <= 3'd0;
			dcount_q <= 2'd0;
			d1_q     <= 8'd0;
			d2_q     <= 8'd0;
		end else if (advance) begin
			phase_q  <= phase_n;
			blink_q  <= blink_n;
			ul_q     <= ul_n;
			color_q  <= color_n;
			pblink_q <= pblink_n;
			pul_q    <= pul_n;
			pcv_q    <= pcv_n;
			pcolor_q <= pcolor_n;
			dcount_q <= dcount_n;
			d1_q     <= d1_n;
			d2_q     <= d2_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= glyph;
		end
	end

`ifndef SYNTHESIS
	a_ul_color_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[11]) |-> (m_tdata[14:12] == 3'd0))
		else $error("underline colour set without underline");

	a_glyph_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] <= 7'd94))
		else $error("glyph index out of printable range");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled input byte lost");
`endif

endmodule
